[sv/hfc_pkg.sv]
// Package for the half/single float converter: field widths, codes and constants.
// No dependencies.
package hfc_pkg;

  localparam int unsigned OperandWidth = 32;
  localparam int unsigned ResultWidth  = 32;
  localparam int unsigned BiasDiff     = 112;

  typedef enum logic {
    FUNC_H2S = 1'b0,
    FUNC_S2H = 1'b1
  } func_t;

  localparam logic [4:0]  HalfExpMax = 5'h1F;
  localparam logic [14:0] HalfInf    = 15'h7C00;
  localparam logic [7:0]  SingleExpMax = 8'hFF;

endpackage

[sv/half_float_converter_core.sv]
// Top level of the half/single float converter: a four-stage pipeline.
// Depends on hfc_pkg.
// A beat passes the capture, leading-zero, normalise and select stages in turn.
// Throughput: one beat per cycle; the pipeline advances when its last stage is free.
// The leading-zero search and exponent rebias are split over separate stages.
// Reset (rst, synchronous, active high) clears all stage valid bits; data is not reset.
module half_float_converter_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // operand[31:0]
  input  logic        s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // result[31:0]
);

  // stage valids
  logic v1, v2, v3, v4;
  logic adv;
  assign adv      = !v4 || m_tready;
  assign s_tready = adv;

  // stage 1: capture and decode
  hfc_pkg::func_t f1;
  logic        sg1;
  logic [4:0]  he1;
  logic [9:0]  hm1;
  logic [7:0]  se1;
  logic [22:0] sm1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (adv) v1 <= s_tvalid;
    if (adv) begin
      f1  <= hfc_pkg::func_t'(s_tuser);
      sg1 <= (s_tuser == hfc_pkg::FUNC_H2S) ? s_tdata[15] : s_tdata[31];
      he1 <= s_tdata[14:10];
      hm1 <= s_tdata[9:0];
      se1 <= s_tdata[30:23];
      sm1 <= s_tdata[22:0];
    end
  end

  // stage 2: leading-zero count of the half mantissa
  logic [3:0] lz;
  always_comb begin
    lz = 4'd10;
    for (int i = 0; i < 10; i++) begin
      if (hm1[i]) lz = 4'(9 - i);
    end
  end

  hfc_pkg::func_t f2;
  logic        sg2;
  logic [4:0]  he2;
  logic [9:0]  hm2;
  logic [7:0]  se2;
  logic [22:0] sm2;
  logic [3:0]  lz2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (adv) v2 <= v1;
    if (adv) begin
      f2 <= f1; sg2 <= sg1; he2 <= he1; hm2 <= hm1;
      se2 <= se1; sm2 <= sm1; lz2 <= lz;
    end
  end

  // stage 3: normalise mantissa, rebias exponents
  hfc_pkg::func_t f3;
  logic        sg3;
  logic [4:0]  he3;
  logic [9:0]  hm3;
  logic [9:0]  nm3;
  logic [7:0]  ne3;
  logic        mz3;
  logic [8:0]  sx3;
  logic [22:0] sm3;
  logic [10:0] shifted;
  assign shifted = {1'b0, hm2} << (lz2 + 4'd1);

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (adv) v3 <= v2;
    if (adv) begin
      f3  <= f2; sg3 <= sg2; he3 <= he2; hm3 <= hm2; sm3 <= sm2;
      nm3 <= shifted[9:0];
      ne3 <= 8'(hfc_pkg::BiasDiff + 1) - {4'd0, lz2} - 8'd1;
      mz3 <= (hm2 == 10'd0);
      sx3 <= {1'b0, se2} - 9'(hfc_pkg::BiasDiff);
    end
  end

  // stage 4: select the result
  logic [31:0] res;
  always_comb begin
    if (f3 == hfc_pkg::FUNC_H2S) begin
      if (he3 == 5'd0) begin
        if (mz3) res = {sg3, 31'd0};
        else     res = {sg3, ne3, nm3, 13'd0};
      end else if (he3 == hfc_pkg::HalfExpMax) begin
        res = {sg3, hfc_pkg::SingleExpMax, hm3, 13'd0};
      end else begin
        res = {sg3, 8'({3'd0, he3} + 8'(hfc_pkg::BiasDiff)), hm3, 13'd0};
      end
    end else begin
      if (sx3[8] || sx3 == 9'd0)
        res = {16'd0, sg3, 15'd0};
      else if (sx3 >= 9'(hfc_pkg::HalfExpMax))
        res = {16'd0, sg3, hfc_pkg::HalfInf};
      else
        res = {16'd0, sg3, sx3[4:0], sm3[22:13]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (adv) v4 <= v3;
    if (adv) m_tdata <= res;
  end
  assign m_tvalid = v4;

  // checks
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output beat dropped while stalled");
  a_half_upper: assert property (@(posedge clk) disable iff (rst)
    adv && v3 && f3 == hfc_pkg::FUNC_S2H |=> m_tdata[31:16] == 16'd0)
    else $error("half result has upper bits set");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> v1)
    else $error("accepted beat not in stage 1");

endmodule

[tb/half_float_converter_core_tb.sv]
// Testbench for half_float_converter_core: drives operand beats in both directions
// and checks every result beat against a behavioural converter held in a scoreboard class.
// Depends on hfc_pkg and half_float_converter_core.
module half_float_converter_core_tb;

  localparam int unsigned IdleLimit = 2000;

  // Behavioural converter and the queue of words still owed by the pipeline
  class conv_scoreboard;
    logic [31:0] owed_words[$];
    int unsigned mismatches;

    function automatic logic [31:0] half_to_single(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] man;
      logic [7:0]  e;
      sgn = {h[15], 31'b0};
      ex  = h[14:10];
      man = {1'b0, h[9:0]};
      if (ex == 5'd0) begin
        if (man == 11'd0) return sgn;
        e = 8'(hfc_pkg::BiasDiff + 1);
        // normalise until the hidden bit shows
        while (man[10] == 1'b0) begin
          man = man << 1;
          e = e - 8'd1;
        end
        return sgn | {1'b0, e, man[9:0], 13'b0};
      end
      if (ex == hfc_pkg::HalfExpMax) return sgn | {1'b0, 8'hFF, man[9:0], 13'b0};
      return sgn | {1'b0, 8'(ex + hfc_pkg::BiasDiff), man[9:0], 13'b0};
    endfunction

    function automatic logic [31:0] single_to_half(logic [31:0] s);
      int ex;
      logic [15:0] sgn;
      sgn = {s[31], 15'b0};
      ex = int'(s[30:23]) - int'(hfc_pkg::BiasDiff);
      if (ex <= 0) return {16'b0, sgn};
      if (ex >= 31) return {16'b0, sgn | {1'b0, hfc_pkg::HalfInf}};
      return {16'b0, sgn | {1'b0, 5'(ex), s[22:13]}};
    endfunction

    function void note_operand(hfc_pkg::func_t f, logic [31:0] op);
      if (f == hfc_pkg::FUNC_H2S) owed_words.push_back(half_to_single(op[15:0]));
      else owed_words.push_back(single_to_half(op));
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] want;
      if (owed_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
        return;
      end
      want = owed_words.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // operand[31:0]
  logic        s_tuser;   // func
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;   // result[31:0]

  conv_scoreboard board;
  bit          sending_done;
  bit          long_hold;
  int unsigned idle_cycles;

  half_float_converter_core dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    board = new();
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    m_tready = 1'b0;
  end

  // Note accepted operands and check result beats at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) board.note_operand(hfc_pkg::func_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) board.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one beat and hold it until taken
  task automatic send_beat(hfc_pkg::func_t f, logic [31:0] op);
    s_tvalid <= 1'b1;
    s_tuser <= f;
    s_tdata <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic pause_sender(int unsigned n);
    s_tvalid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Random operand biased toward exponent edges and subnormals
  function automatic logic [31:0] random_operand(hfc_pkg::func_t f);
    logic [31:0] op;
    op = $urandom;
    case ($urandom_range(0, 5))
      0: if (f == hfc_pkg::FUNC_H2S) op[14:10] = 5'd0;
         else op[30:23] = 8'($urandom_range(110, 114));
      1: if (f == hfc_pkg::FUNC_H2S) op[14:10] = 5'h1F;
         else op[30:23] = 8'($urandom_range(140, 144));
      2: if (f == hfc_pkg::FUNC_S2H) op[30:23] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: ;
    endcase
    return op;
  endfunction

  // Receiver: its own stall pattern, with one long hold-off on request
  initial begin
    int unsigned phase;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (60) @(posedge clk);
        long_hold = 1'b0;
      end
      phase = (phase + 1) % 40;
      if (phase < 15) m_tready <= 1'b1;
      else m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  // Sender: directed corners, then random bursts
  initial begin
    logic [31:0] corners[$];
    int unsigned burst;
    hfc_pkg::func_t f;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    corners = '{32'h0000_0000, 32'h0000_8000, 32'h0000_0001, 32'h0000_83FF, 32'h0000_0400,
                32'h0000_7BFF, 32'h0000_7C00, 32'h0000_FC00, 32'h0000_7E01, 32'hFFFF_3C00,
                32'hABCD_0200};
    foreach (corners[i]) send_beat(hfc_pkg::FUNC_H2S, corners[i]);
    corners = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h3880_0000, 32'h387F_FFFF,
                32'h477F_FFFF, 32'hC780_0000, 32'h7F80_0000, 32'h7FC0_1234, 32'hFFFF_FFFF,
                32'h3F80_1FFF, 32'h8080_0000};
    foreach (corners[i]) send_beat(hfc_pkg::FUNC_S2H, corners[i]);
    // Hold the sink off while beats keep coming so the pipeline backs up
    long_hold = 1'b1;
    repeat (20) begin
      f = hfc_pkg::func_t'($urandom_range(0, 1));
      send_beat(f, random_operand(f));
    end
    // Let the pipeline drain completely
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (board.owed_words.size() != 0) @(posedge clk);
    for (int n = 0; n < 1000; n += burst) begin
      burst = $urandom_range(1, 30);
      for (int k = 0; k < burst; k++) begin
        f = hfc_pkg::func_t'($urandom_range(0, 1));
        send_beat(f, random_operand(f));
      end
      if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 8));
    end
    s_tvalid <= 1'b0;
    sending_done = 1'b1;
  end

  // Wait for the last results, or stop when nothing moves for too long
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (idle_cycles >= IdleLimit) begin
        $display("== FAIL ==");
        $finish;
      end
      if (sending_done && board.owed_words.size() == 0) begin
        repeat (10) @(posedge clk);
        if (board.mismatches == 0 && board.owed_words.size() == 0) begin
          $display("== PASS ==");
        end else begin
          $display("== FAIL ==");
        end
        $finish;
      end
    end
  end

endmodule
